FILE: design/bmps_pkg.sv
// ----------------------------------------------------------------------------
// Bus master poll scheduler package
// Item types, table entry types, codes and constants shared by the block.
// ----------------------------------------------------------------------------
package bmps_pkg;

	localparam int MAX_CHANNELS_DEF = 64;

	// Item actions.
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_POLL  = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
	localparam logic [1:0] CFG_PAUSE_TICKS   = 2'd1;
	localparam logic [1:0] CFG_MASTER_ENABLE = 2'd2;

	// Channel status codes.
	localparam logic [1:0] ST_PENDING = 2'd0;
	localparam logic [1:0] ST_OK      = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	localparam logic [2:0]  ERR_LIMIT         = 3'd5;
	localparam logic [15:0] PAUSE_RESET       = 16'd5;
	localparam logic [15:0] TIMEOUT_RESET     = 16'd100;
	localparam logic [7:0]  PAUSE_TICKS_RESET = 8'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic        response_complete;
		logic        response_valid;
		logic [5:0]  entry_index;
		logic        entry_enable;
		logic [15:0] entry_timeout;
	} in_item_t;

	typedef struct packed {
		logic       request_sent;
		logic [5:0] current_channel;
		logic       response_ok;
		logic       timeout_seen;
		logic       timeout_error_set;
		logic       restore_settings;
		logic       led;
	} result_t;

	// Entry fields written by table writes.
	typedef struct packed {
		logic        enabled;
		logic [15:0] timeout;
	} cfg_entry_t;

	// Entry fields written by poll steps.
	typedef struct packed {
		logic [2:0] err_count;
		logic [1:0] status;
	} st_entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic poll_active;
	} stat_t;

endpackage

FILE: design/bmps_table.sv
// ----------------------------------------------------------------------------
// Channel table
// Two simple dual-port memories with registered reads: line settings written by
// table writes, and status written by poll steps. Valid bits per entry give
// the reset contents until an entry is first written.
// ----------------------------------------------------------------------------
module bmps_table
	import bmps_pkg::*;
#(
	parameter int DEPTH = MAX_CHANNELS_DEF,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_addr,
	output cfg_entry_t       rd_cfg,
	output st_entry_t        rd_st,
	input  logic             wr_cfg,
	input  logic [IDX_W-1:0] wr_cfg_addr,
	input  cfg_entry_t       wr_cfg_data,
	input  logic             wr_st,
	input  logic [IDX_W-1:0] wr_st_addr,
	input  st_entry_t        wr_st_data
);

	cfg_entry_t mem_cfg [DEPTH];
	st_entry_t  mem_st  [DEPTH];
	logic [DEPTH-1:0] vld_cfg_q;
	logic [DEPTH-1:0] vld_st_q;
	cfg_entry_t rd_cfg_q;
	st_entry_t  rd_st_q;
	logic       rd_vcfg_q;
	logic       rd_vst_q;

	always_ff @(posedge clk) begin
		if (wr_cfg) begin
			mem_cfg[wr_cfg_addr] <= wr_cfg_data;
		end
		if (wr_st) begin
			mem_st[wr_st_addr] <= wr_st_data;
		end
		rd_cfg_q <= mem_cfg[rd_addr];
		rd_st_q  <= mem_st[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_cfg_q <= '0;
			vld_st_q  <= '0;
			rd_vcfg_q <= 1'b0;
			rd_vst_q  <= 1'b0;
		end else begin
			if (wr_cfg) begin
				vld_cfg_q[wr_cfg_addr] <= 1'b1;
			end
			if (wr_st) begin
				vld_st_q[wr_st_addr] <= 1'b1;
			end
			rd_vcfg_q <= vld_cfg_q[rd_addr];
			rd_vst_q  <= vld_st_q[rd_addr];
		end
	end

	// An entry never written reads as its reset contents.
	always_comb begin
		if (rd_vcfg_q) begin
			rd_cfg = rd_cfg_q;
		end else begin
			rd_cfg.enabled = 1'b0;
			rd_cfg.timeout = TIMEOUT_RESET;
		end
		if (rd_vst_q) begin
			rd_st = rd_st_q;
		end else begin
			rd_st.err_count = '0;
			rd_st.status    = ST_PENDING;
		end
	end

endmodule

FILE: design/bmps_ctrl.sv
// ----------------------------------------------------------------------------
// Poll scheduler controller
// Sequences each item through execution, with a table lookup first for an
// active poll step, and marks the result cycle.
// ----------------------------------------------------------------------------
module bmps_ctrl
	import bmps_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	state_t state_q;
	state_t state_n;
	logic   done_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_n = stat.poll_active ? S_LOOKUP : S_EXEC;
				end
			end
			S_LOOKUP: begin
				state_n = S_EXEC;
			end
			S_EXEC: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= cmd.exec;
		end
	end

	assign done = done_q;

endmodule

FILE: design/bmps_dp.sv
// ----------------------------------------------------------------------------
// Poll scheduler datapath
// Configuration registers, tick timers, round-robin indexes, LED state, the
// channel table and the result register.
// ----------------------------------------------------------------------------
module bmps_dp
	import bmps_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output stat_t      stat,
	input  in_item_t   item,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CW    = (IDX_W + 1 > 7) ? IDX_W + 1 : 7;

	logic [6:0]  chan_count_q;
	logic [7:0]  pause_ticks_q;
	logic        master_en_q;

	in_item_t    item_q;
	logic        poll_act_q;
	logic        sel_q;
	logic [IDX_W-1:0] serving_q;
	logic [IDX_W-1:0] next_q;
	logic [15:0] pause_q;
	logic [15:0] rsp_q;
	logic        round_err_q;
	logic        led_q;
	result_t     res_q;

	logic [CW-1:0]    count_eff;
	logic             sel;
	logic             wrap;
	logic [IDX_W-1:0] rd_addr;
	cfg_entry_t       rd_cfg;
	st_entry_t        rd_st;
	logic             slot_ok;
	logic             wr_cfg;
	logic             wr_st;
	cfg_entry_t       wr_cfg_data;
	st_entry_t        wr_st_data;

	logic [16:0] load_sum;
	logic [15:0] load_pause;
	logic [15:0] rt1;
	logic [15:0] pt1;
	logic [1:0]  st1;
	logic [15:0] pause_n;
	logic [15:0] rsp_n;
	logic        set_round_err;
	result_t     res_n;

	// Counts above the table depth behave as the table depth.
	assign count_eff = (CW'(chan_count_q) > CW'(MAX_CHANNELS)) ?
		CW'(MAX_CHANNELS) : CW'(chan_count_q);

	assign stat.poll_active = (item.action == ACT_POLL) && (chan_count_q != '0) && master_en_q;

	assign sel     = (pause_q == '0) && (rsp_q == '0);
	assign wrap    = (CW'(next_q) + CW'(1)) >= count_eff;
	assign rd_addr = sel ? next_q : serving_q;
	assign slot_ok = CW'(item_q.entry_index) < CW'(MAX_CHANNELS);

	bmps_table #(
		.DEPTH(MAX_CHANNELS),
		.IDX_W(IDX_W)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_addr     (rd_addr),
		.rd_cfg      (rd_cfg),
		.rd_st       (rd_st),
		.wr_cfg      (wr_cfg),
		.wr_cfg_addr (IDX_W'(item_q.entry_index)),
		.wr_cfg_data (wr_cfg_data),
		.wr_st       (wr_st),
		.wr_st_addr  (serving_q),
		.wr_st_data  (wr_st_data)
	);

	assign wr_cfg = cmd.exec && (item_q.action == ACT_WRITE) && slot_ok;
	assign wr_cfg_data.enabled = item_q.entry_enable;
	assign wr_cfg_data.timeout = item_q.entry_timeout;
	assign wr_st = cmd.exec && poll_act_q && rd_cfg.enabled;

	// Timer load on a new request saturates at the top of the 16-bit range.
	assign load_sum   = {1'b0, rd_cfg.timeout} + 17'(pause_ticks_q);
	assign load_pause = load_sum[16] ? 16'hFFFF : load_sum[15:0];

	assign rt1 = sel_q ? rd_cfg.timeout : rsp_q;
	assign pt1 = sel_q ? load_pause : pause_q;
	assign st1 = sel_q ? ST_PENDING : rd_st.status;

	always_comb begin
		pause_n       = pause_q;
		rsp_n         = rsp_q;
		set_round_err = 1'b0;
		wr_st_data    = rd_st;
		res_n         = '0;
		if (item_q.action == ACT_TICK) begin
			if (pause_q != '0) begin
				pause_n = pause_q - 16'd1;
			end
			if (rsp_q != '0) begin
				rsp_n = rsp_q - 16'd1;
			end
		end else if (poll_act_q && rd_cfg.enabled) begin
			res_n.request_sent = sel_q;
			pause_n            = pt1;
			rsp_n              = rt1;
			wr_st_data.status  = st1;
			if (rt1 != '0) begin
				if (item_q.response_complete && item_q.response_valid) begin
					res_n.response_ok    = 1'b1;
					wr_st_data.err_count = '0;
					wr_st_data.status    = ST_OK;
					pause_n              = 16'(pause_ticks_q);
					rsp_n                = '0;
				end
			end else begin
				res_n.restore_settings = 1'b1;
				// A timeout is counted once per request, on the first step after expiry.
				if (st1 == ST_PENDING) begin
					wr_st_data.status  = ST_TIMEOUT;
					res_n.timeout_seen = 1'b1;
					if (rd_st.err_count < ERR_LIMIT) begin
						wr_st_data.err_count = rd_st.err_count + 3'd1;
					end else begin
						res_n.timeout_error_set = 1'b1;
						set_round_err           = 1'b1;
					end
				end
			end
		end
		res_n.current_channel = 6'(serving_q);
		res_n.led             = led_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q     <= item;
			poll_act_q <= stat.poll_active;
		end
		if (cmd.lookup) begin
			sel_q <= sel;
		end
		if (cmd.exec) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count_q  <= '0;
			pause_ticks_q <= PAUSE_TICKS_RESET;
			master_en_q   <= 1'b0;
			serving_q     <= '0;
			next_q        <= '0;
			pause_q       <= PAUSE_RESET;
			rsp_q         <= '0;
			round_err_q   <= 1'b0;
			led_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHANNEL_COUNT: chan_count_q  <= cfg_data[6:0];
					CFG_PAUSE_TICKS:   pause_ticks_q <= cfg_data;
					CFG_MASTER_ENABLE: master_en_q   <= cfg_data[0];
					default: begin
						master_en_q <= master_en_q;
					end
				endcase
			end
			if (cmd.lookup && sel) begin
				serving_q <= next_q;
				if (wrap) begin
					next_q <= '0;
					if (round_err_q) begin
						led_q       <= 1'b1;
						round_err_q <= 1'b0;
					end else begin
						led_q <= ~led_q;
					end
				end else begin
					next_q <= next_q + IDX_W'(1);
				end
			end
			if (cmd.exec) begin
				pause_q <= pause_n;
				rsp_q   <= rsp_n;
				if (set_round_err) begin
					round_err_q <= 1'b1;
				end
			end
		end
	end

	assign result = res_q;

	a_ok_closes_window: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && res_n.response_ok) |=> (rsp_q == '0))
		else $error("valid response left the response timer running");

	a_ok_excl_restore: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(res_n.response_ok && res_n.restore_settings))
		else $error("response accepted and window closed in the same step");

	a_err_needs_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && res_n.timeout_error_set) |=> (round_err_q && res_q.timeout_seen))
		else $error("timeout error raised without a counted timeout");

	a_next_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.lookup && sel && !wrap) |=> (CW'(next_q) < count_eff))
		else $error("next channel index left the round");

endmodule

FILE: design/bus_master_poll_scheduler.sv
// ----------------------------------------------------------------------------
// Bus master poll scheduler
// Round-robin poller for a shared serial bus: tick timers, per-channel
// response timeouts, error counting and a round status LED.
// ----------------------------------------------------------------------------
//  Channel   Signals                                 Accepted when
//  input     start, busy, item                       start && !busy
//  result    done, result                            done (one cycle, no hold-off)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// A tick, a table write or an idle poll step goes from accept through the execute
// state to its result strobe; a poll step that reaches the table passes through
// the lookup state first, because the channel entry is read from a memory with a registered read port.
// The next item is accepted in the cycle that the previous result is shown.
// After reset the table reads as its reset contents through per-entry valid
// bits, so no clearing pass is needed. Results cannot be stalled.
// ----------------------------------------------------------------------------
module bus_master_poll_scheduler
	import bmps_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_item_t   item,
	output logic       done,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	bmps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bmps_dp #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item      (item),
		.result    (result),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

FILE: tb/sv/tb_bus_master_poll_scheduler.sv
// ----------------------------------------------------------------------------
// Bus master poll scheduler testbench
// Drives ticks, poll steps and table writes through the command port and
// rewrites the three registers between phases. A poller model in this file
// predicts one result per accepted item, and each strobed result is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bus_master_poll_scheduler
	import bmps_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;
	localparam int CHANNELS = MAX_CHANNELS_DEF;
	localparam int ITEM_W = $bits(in_item_t);
	localparam int GAP_MAX = 12;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct {
		in_item_t    item;
		int unsigned gap;
	} queued_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	in_item_t   item = '0;
	logic       done;
	result_t    result;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	queued_item_t pending_items[$];
	result_t      expected_results[$];
	int           mismatches = 0;
	bit           burst_run = 1'b0;

	// Poller model state and register copies.
	logic        chan_on [CHANNELS];
	logic [15:0] chan_window [CHANNELS];
	logic [2:0]  chan_misses [CHANNELS];
	logic [1:0]  chan_state [CHANNELS];
	logic [5:0]  serving_slot;
	logic [5:0]  next_slot;
	int unsigned pause_left;
	int unsigned reply_left;
	logic        round_fault;
	logic        led_q;
	logic [6:0]  poll_count;
	logic [7:0]  pause_setting;
	logic        master_on;

	bus_master_poll_scheduler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = !clk;

	function automatic void reset_poller();
		for (int i = 0; i < CHANNELS; i++) begin
			chan_on[i] = 1'b0;
			chan_window[i] = TIMEOUT_RESET;
			chan_misses[i] = '0;
			chan_state[i] = ST_PENDING;
		end
		serving_slot = '0;
		next_slot = '0;
		pause_left = 32'(PAUSE_RESET);
		reply_left = 0;
		round_fault = 1'b0;
		led_q = 1'b0;
		poll_count = '0;
		pause_setting = PAUSE_TICKS_RESET;
		master_on = 1'b0;
	endfunction

	function automatic result_t advance_poller(in_item_t it);
		result_t r;
		int count;
		int unsigned load;
		r = '0;
		case (it.action)
			ACT_TICK: begin
				if (pause_left != 0)
					pause_left--;
				if (reply_left != 0)
					reply_left--;
			end
			ACT_POLL: begin
				count = (int'(poll_count) > CHANNELS) ? CHANNELS : int'(poll_count);
				if (count != 0 && master_on) begin
					// Both timers idle: move on to the next slot of the round.
					if (pause_left == 0 && reply_left == 0) begin
						serving_slot = next_slot;
						if (int'(next_slot) + 1 >= count) begin
							next_slot = '0;
							if (!round_fault) begin
								led_q = !led_q;
							end else begin
								led_q = 1'b1;
								round_fault = 1'b0;
							end
						end else begin
							next_slot = next_slot + 6'd1;
						end
						if (chan_on[serving_slot]) begin
							chan_state[serving_slot] = ST_PENDING;
							r.request_sent = 1'b1;
							reply_left = 32'(chan_window[serving_slot]);
							load = int'(chan_window[serving_slot]) + int'(pause_setting);
							pause_left = (load > 65535) ? 65535 : load;
						end
					end
					if (chan_on[serving_slot]) begin
						if (reply_left != 0) begin
							if (it.response_complete && it.response_valid) begin
								r.response_ok = 1'b1;
								chan_misses[serving_slot] = '0;
								chan_state[serving_slot] = ST_OK;
								pause_left = 32'(pause_setting);
								reply_left = 0;
							end
						end else begin
							// A timeout is only counted once for each request.
							r.restore_settings = 1'b1;
							if (chan_state[serving_slot] == ST_PENDING) begin
								chan_state[serving_slot] = ST_TIMEOUT;
								r.timeout_seen = 1'b1;
								if (chan_misses[serving_slot] < ERR_LIMIT) begin
									chan_misses[serving_slot]++;
								end else begin
									r.timeout_error_set = 1'b1;
									round_fault = 1'b1;
								end
							end
						end
					end
				end
			end
			ACT_WRITE: begin
				chan_on[it.entry_index] = it.entry_enable;
				chan_window[it.entry_index] = it.entry_timeout;
			end
			default: ;
		endcase
		r.current_channel = serving_slot;
		r.led = led_q;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Fields that an action does not use still carry random bits.
	function automatic in_item_t noise_item(logic [1:0] act);
		in_item_t it;
		it = in_item_t'(ITEM_W'($urandom()));
		it.action = act;
		return it;
	endfunction

	function automatic in_item_t poll_item(logic complete, logic valid);
		in_item_t it;
		it = noise_item(ACT_POLL);
		it.response_complete = complete;
		it.response_valid = valid;
		return it;
	endfunction

	function automatic in_item_t table_item(logic [5:0] slot, logic enable, logic [15:0] window);
		in_item_t it;
		it = noise_item(ACT_WRITE);
		it.entry_index = slot;
		it.entry_enable = enable;
		it.entry_timeout = window;
		return it;
	endfunction

	function automatic void queue_item(in_item_t it);
		queued_item_t q;
		if ($urandom_range(0, 99) < 6)
			burst_run = !burst_run;
		q.item = it;
		q.gap = burst_run ? 0 : $urandom_range(0, GAP_MAX);
		pending_items.push_back(q);
	endfunction

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || start || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CHANNEL_COUNT: poll_count = value[6:0];
			CFG_PAUSE_TICKS:   pause_setting = value;
			CFG_MASTER_ENABLE: master_on = value[0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [7:0] count, logic [7:0] pause, logic master);
		write_register(CFG_CHANNEL_COUNT, count);
		write_register(CFG_PAUSE_TICKS, pause);
		write_register(CFG_MASTER_ENABLE, {7'd0, master});
	endtask

	// Mostly bursts of ticks closed by a poll step, with table writes and
	// stray items mixed in. good_pct sets how often a poll carries an answer.
	task automatic run_phase(logic [7:0] count, logic [7:0] pause, logic master,
			int good_pct, int tick_span, int n_items);
		int made;
		int roll;
		int span;
		in_item_t it;
		configure(count, pause, master);
		@(negedge clk);
		made = 0;
		span = (int'(poll_count) > CHANNELS) ? CHANNELS : int'(poll_count);
		if (span == 0)
			span = 8;
		while (made < n_items) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				it = table_item(
					6'(($urandom_range(0, 99) < 80) ? $urandom_range(0, span - 1)
						: $urandom_range(0, CHANNELS - 1)),
					$urandom_range(0, 99) < 75,
					16'(($urandom_range(0, 99) < 90) ? $urandom_range(0, 6)
						: $urandom_range(0, 65535)));
				queue_item(it);
				made++;
			end else if (roll < 11) begin
				it = noise_item(2'($urandom_range(0, 3)));
				queue_item(it);
				if (it.action != ACT_NONE)
					made++;
			end else begin
				repeat ($urandom_range(0, tick_span)) begin
					queue_item(noise_item(ACT_TICK));
					made++;
				end
				if ($urandom_range(0, 99) < good_pct)
					queue_item(poll_item(1'b1, 1'b1));
				else
					queue_item(poll_item(1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1))));
				made++;
			end
		end
		wait_quiet();
	endtask

	always @(posedge clk) begin : drive_items
		queued_item_t head;
		if (arst_n) begin
			if (start && !busy)
				expected_results.push_back(advance_poller(item));
			if (!start || !busy) begin
				if (pending_items.size() == 0) begin
					start <= 1'b0;
				end else if (pending_items[0].gap != 0) begin
					pending_items[0].gap--;
					start <= 1'b0;
				end else begin
					head = pending_items.pop_front();
					item <= head.item;
					start <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 32'(result), '0);
			end else begin
				want = expected_results.pop_front();
				if (result.request_sent !== want.request_sent)
					report_mismatch("request_sent", 32'(result.request_sent),
						32'(want.request_sent));
				if (result.current_channel !== want.current_channel)
					report_mismatch("current_channel", 32'(result.current_channel),
						32'(want.current_channel));
				if (result.response_ok !== want.response_ok)
					report_mismatch("response_ok", 32'(result.response_ok),
						32'(want.response_ok));
				if (result.timeout_seen !== want.timeout_seen)
					report_mismatch("timeout_seen", 32'(result.timeout_seen),
						32'(want.timeout_seen));
				if (result.timeout_error_set !== want.timeout_error_set)
					report_mismatch("timeout_error_set", 32'(result.timeout_error_set),
						32'(want.timeout_error_set));
				if (result.restore_settings !== want.restore_settings)
					report_mismatch("restore_settings", 32'(result.restore_settings),
						32'(want.restore_settings));
				if (result.led !== want.led)
					report_mismatch("led", 32'(result.led), 32'(want.led));
			end
		end
	end

	initial begin
		reset_poller();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings leave the round empty, so the poll step is idle.
		@(negedge clk);
		queue_item(poll_item(1'b1, 1'b1));
		queue_item(noise_item(ACT_TICK));
		queue_item(noise_item(ACT_NONE));
		queue_item(table_item(6'd0, 1'b1, 16'd0));
		queue_item(table_item(6'd1, 1'b1, 16'd2));
		queue_item(table_item(6'd2, 1'b0, 16'd7));
		queue_item(table_item(6'd3, 1'b1, 16'hFFFF));
		queue_item(table_item(6'd63, 1'b1, 16'hFFFF));
		wait_quiet();

		// Channels in the round but polling switched off.
		configure(8'd4, 8'd0, 1'b0);
		@(negedge clk);
		queue_item(poll_item(1'b1, 1'b1));
		wait_quiet();

		// Drain the reset pause, then a zero window, an answer and an absent slot.
		write_register(CFG_MASTER_ENABLE, 8'd1);
		@(negedge clk);
		repeat (5) queue_item(noise_item(ACT_TICK));
		queue_item(poll_item(1'b0, 1'b0));
		queue_item(poll_item(1'b1, 1'b1));
		queue_item(poll_item(1'b1, 1'b1));
		wait_quiet();

		// The widest window plus the longest pause saturates the pause timer.
		write_register(CFG_PAUSE_TICKS, 8'd255);
		@(negedge clk);
		queue_item(poll_item(1'b0, 1'b0));
		wait_quiet();
		write_register(CFG_PAUSE_TICKS, 8'd0);
		@(negedge clk);
		queue_item(poll_item(1'b1, 1'b1));
		wait_quiet();

		run_phase(8'd6, 8'd1, 1'b1, 50, 6, 200);
		run_phase(8'd3, 8'd0, 1'b1, 10, 4, 200);
		// Bit 7 of the write is dropped and the count is clamped to the table size.
		run_phase(8'hC5, 8'd0, 1'b1, 40, 3, 200);
		run_phase(8'd1, 8'd2, 1'b1, 20, 5, 150);
		run_phase(8'd5, 8'd255, 1'b1, 60, 300, 220);
		run_phase(8'd4, 8'd3, 1'b0, 50, 4, 80);
		run_phase(8'd0, 8'd1, 1'b1, 50, 4, 60);
		run_phase(8'd64, 8'd0, 1'b1, 30, 3, 150);
		run_phase(8'd2, 8'd7, 1'b1, 5, 10, 120);

		if (mismatches == 0)
			$display("tb_bus_master_poll_scheduler: done, clean");
		else
			$display("tb_bus_master_poll_scheduler: done, errors");
		$finish;
	end

	initial begin
		#2ms;
		$display("%0t: timed out", $realtime);
		$display("tb_bus_master_poll_scheduler: done, errors");
		$finish;
	end

endmodule

FILE: bus_master_poll_scheduler.f
design/bmps_pkg.sv
design/bmps_table.sv
design/bmps_ctrl.sv
design/bmps_dp.sv
design/bus_master_poll_scheduler.sv
tb/sv/tb_bus_master_poll_scheduler.sv
